[rtl/bgra_thumbnail_downscaler_defines.svh]
// assertion macros for the bgra thumbnail downscaler
// no dependencies; included by modules that carry assertions
`ifndef BGRA_THUMBNAIL_DOWNSCALER_DEFINES_SVH
`define BGRA_THUMBNAIL_DOWNSCALER_DEFINES_SVH

// same-cycle implication, sampled on aclk, off during reset
`define BTD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off during reset
`define BTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/btd_pkg.sv]
// shared types and constants for the bgra thumbnail downscaler
// no dependencies
package btd_pkg;

    localparam int PIX_W          = 8;
    localparam int SRC_W          = 13;
    localparam int DST_W          = 12;
    localparam int SUM_W          = 32;
    localparam int CFG_W          = 13;
    localparam int CFG_IDX_W      = 2;
    localparam int MAX_SRC_DIM    = 4096;
    localparam int MAX_DST_WIDTH  = 2048;
    localparam int MAX_DST_HEIGHT = 2048;

    localparam logic [SRC_W-1:0] RST_SRC_WIDTH  = 13'd1920;
    localparam logic [SRC_W-1:0] RST_SRC_HEIGHT = 13'd1080;
    localparam logic [DST_W-1:0] RST_DST_WIDTH  = 12'd960;
    localparam logic [DST_W-1:0] RST_DST_HEIGHT = 12'd540;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_DST_WIDTH  = 2'd2,
        REG_DST_HEIGHT = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_CLAMP,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_MUL,
        ST_IDLE,
        ST_ACC,
        ST_AVG
    } state_t;

endpackage

[rtl/btd_div.sv]
// iterative restoring divider, one quotient bit per cycle
// uses btd_pkg only through its parent's widths
module btd_div #(
    parameter int W = 13
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] num,
    input  logic [W-1:0] den,
    output logic         busy,
    output logic [W-1:0] quot,
    output logic [W-1:0] rem
);

    localparam int CW = $clog2(W + 1);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  q_reg;
    logic [W-1:0]  rem_reg;
    logic [W:0]    trial;
    logic          fits;

    assign trial = {rem_reg, q_reg[W-1]};
    assign fits  = trial >= {1'b0, den};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= num;
            rem_reg <= '0;
        end else if (busy_reg) begin
            q_reg   <= {q_reg[W-2:0], fits};
            rem_reg <= fits ? W'(trial - {1'b0, den}) : trial[W-1:0];
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;
    assign rem  = rem_reg;

endmodule

[rtl/bgra_thumbnail_downscaler.sv]
// top level of the bgra thumbnail downscaler: box average or nearest neighbour
// depends on btd_pkg, btd_div and bgra_thumbnail_downscaler_defines.svh
//
//  port group   direction  contents
//  s_*          in         source pixel transfer: blue, green, red
//  m_*          out        thumbnail pixel transfer: red, green, blue, last_of_frame
//  cfg_*        in         register write: index, data (no read-back)
//
// nearest-neighbour ratios: one source pixel per cycle unless a result waits
// integer ratios: per pixel a read then a write of the sum memory (IDLE, ACC),
//   and the shift-subtract averager on a box's last pixel; no transfer meanwhile
// after reset and each register write a setup pass (clamp, divide, multiply)
//   runs the two 13-bit dividers for the ratios; no source transfer meanwhile
// a waiting result blocks only the next source transfer, not the current work
`include "bgra_thumbnail_downscaler_defines.svh"

module bgra_thumbnail_downscaler #(
    parameter int MAX_SRC_DIM   = btd_pkg::MAX_SRC_DIM,
    parameter int MAX_DST_WIDTH = btd_pkg::MAX_DST_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [btd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [btd_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [btd_pkg::PIX_W-1:0]     s_blue_in,
    input  logic [btd_pkg::PIX_W-1:0]     s_green_in,
    input  logic [btd_pkg::PIX_W-1:0]     s_red_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [btd_pkg::PIX_W-1:0]     m_red_out,
    output logic [btd_pkg::PIX_W-1:0]     m_green_out,
    output logic [btd_pkg::PIX_W-1:0]     m_blue_out,
    output logic                          m_last_of_frame
);

    localparam int SW    = btd_pkg::SRC_W;
    localparam int DW    = btd_pkg::DST_W;
    localparam int PW    = btd_pkg::PIX_W;
    localparam int SUMW  = btd_pkg::SUM_W;
    localparam int AW    = $clog2(MAX_DST_WIDTH);
    localparam int BSZW  = 2 * SW;
    localparam int DSHW  = BSZW + PW - 1;
    localparam int CMPW  = SW + 1;
    localparam logic [CMPW-1:0] MAX_SRC_C = CMPW'(MAX_SRC_DIM);
    localparam logic [CMPW-1:0] MAX_DW_C  = CMPW'(MAX_DST_WIDTH);
    localparam logic [CMPW-1:0] MAX_DH_C  = CMPW'(btd_pkg::MAX_DST_HEIGHT);
    localparam logic [DW-1:0]   IDX_MAX   = DW'(MAX_DST_WIDTH - 1);

    // configuration registers
    logic [SW-1:0] src_width_reg, src_height_reg;
    logic [DW-1:0] dst_width_reg, dst_height_reg;

    // effective sizes and ratios from the setup pass
    logic [SW-1:0]   sw_reg, sh_reg;
    logic [DW-1:0]   dw_reg, dh_reg;
    logic [SW-1:0]   rx_reg, ry_reg, remx_reg, remy_reg;
    logic [BSZW-1:0] bsz_reg;
    logic            int_mode_reg;

    // position counters
    logic [SW-1:0] sc_reg, sr_reg, bx_reg, by_reg, pc_reg, pr_reg;
    logic [DW-1:0] ox_reg, oy_reg, oc_reg, orow_reg, pcf_reg, prf_reg;

    // item latched at transfer
    logic [PW-1:0] pix_r_reg, pix_g_reg, pix_b_reg;
    logic [AW-1:0] idx_reg;
    logic          first_reg, last_reg, lof_reg;

    // sum memory, red/green/blue packed per entry
    logic [3*SUMW-1:0] sum_mem [MAX_DST_WIDTH];
    logic [3*SUMW-1:0] rd_data_reg;
    logic [3*SUMW-1:0] acc_sum;

    // averager
    logic [DSHW-1:0] ar_reg, ag_reg, ab_reg, dsh_reg;
    logic [PW-1:0]   qr_reg, qg_reg, qb_reg;
    logic [3:0]      avg_cnt_reg;
    logic            br, bg, bb;

    // output register
    logic          m_valid_reg;
    logic [PW-1:0] m_r_reg, m_g_reg, m_b_reg;
    logic          m_lof_reg;

    btd_pkg::state_t st_reg, st_next;

    logic            div_start, mem_we;
    logic            xfer_in, xfer_out;
    logic            col_last, row_last, nn_hit;
    logic [SW-1:0]   div_x_q, div_x_r, div_y_q, div_y_r;
    logic            div_x_busy, div_y_busy;
    logic [CMPW-1:0] sw_c, sh_c, dwlim, dhlim;
    logic [SW-1:0]   sw_eff, sh_eff;
    logic [DW-1:0]   dw_eff, dh_eff;
    logic [SW:0]     pcf_sum, prf_sum;

    assign xfer_in  = s_valid && s_ready;
    assign xfer_out = m_valid_reg && m_ready;

    // clamping of the size registers
    always_comb begin
        sw_c = (src_width_reg == '0) ? CMPW'(1) :
               ({1'b0, src_width_reg} > MAX_SRC_C) ? MAX_SRC_C : {1'b0, src_width_reg};
        sh_c = (src_height_reg == '0) ? CMPW'(1) :
               ({1'b0, src_height_reg} > MAX_SRC_C) ? MAX_SRC_C : {1'b0, src_height_reg};
        dwlim = (sw_c < MAX_DW_C) ? sw_c : MAX_DW_C;
        dhlim = (sh_c < MAX_DH_C) ? sh_c : MAX_DH_C;
        sw_eff = sw_c[SW-1:0];
        sh_eff = sh_c[SW-1:0];
        dw_eff = (dst_width_reg == '0) ? DW'(1) :
                 ({2'b0, dst_width_reg} > dwlim) ? dwlim[DW-1:0] : dst_width_reg;
        dh_eff = (dst_height_reg == '0) ? DW'(1) :
                 ({2'b0, dst_height_reg} > dhlim) ? dhlim[DW-1:0] : dst_height_reg;
    end

    btd_div #(.W(SW)) u_div_x (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(sw_reg), .den({1'b0, dw_reg}),
        .busy(div_x_busy), .quot(div_x_q), .rem(div_x_r)
    );

    btd_div #(.W(SW)) u_div_y (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(sh_reg), .den({1'b0, dh_reg}),
        .busy(div_y_busy), .quot(div_y_q), .rem(div_y_r)
    );

    // next state
    always_comb begin
        st_next = st_reg;
        case (st_reg)
            btd_pkg::ST_CLAMP:     st_next = btd_pkg::ST_DIV_START;
            btd_pkg::ST_DIV_START: st_next = btd_pkg::ST_DIV_WAIT;
            btd_pkg::ST_DIV_WAIT: begin
                if (!div_x_busy && !div_y_busy) begin
                    st_next = btd_pkg::ST_MUL;
                end
            end
            btd_pkg::ST_MUL:       st_next = btd_pkg::ST_IDLE;
            btd_pkg::ST_IDLE: begin
                if (xfer_in && int_mode_reg) begin
                    st_next = btd_pkg::ST_ACC;
                end
            end
            btd_pkg::ST_ACC:       st_next = last_reg ? btd_pkg::ST_AVG : btd_pkg::ST_IDLE;
            btd_pkg::ST_AVG: begin
                if (avg_cnt_reg == 4'd1) begin
                    st_next = btd_pkg::ST_IDLE;
                end
            end
            default:               st_next = btd_pkg::ST_CLAMP;
        endcase
        if (cfg_wr_en) begin
            st_next = btd_pkg::ST_CLAMP;
        end
    end

    // state outputs
    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        mem_we    = 1'b0;
        case (st_reg)
            btd_pkg::ST_IDLE:      s_ready   = !m_valid_reg || m_ready;
            btd_pkg::ST_DIV_START: div_start = 1'b1;
            btd_pkg::ST_ACC:       mem_we    = 1'b1;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= btd_pkg::ST_CLAMP;
        end else begin
            st_reg <= st_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= btd_pkg::RST_SRC_WIDTH;
            src_height_reg <= btd_pkg::RST_SRC_HEIGHT;
            dst_width_reg  <= btd_pkg::RST_DST_WIDTH;
            dst_height_reg <= btd_pkg::RST_DST_HEIGHT;
        end else if (cfg_wr_en) begin
            case (btd_pkg::cfg_idx_t'(cfg_index))
                btd_pkg::REG_SRC_WIDTH:  src_width_reg  <= cfg_wdata;
                btd_pkg::REG_SRC_HEIGHT: src_height_reg <= cfg_wdata;
                btd_pkg::REG_DST_WIDTH:  dst_width_reg  <= cfg_wdata[DW-1:0];
                btd_pkg::REG_DST_HEIGHT: dst_height_reg <= cfg_wdata[DW-1:0];
                default:                 src_width_reg  <= src_width_reg;
            endcase
        end
    end

    // setup pass: clamp, divide, block size
    always_ff @(posedge aclk) begin
        if (st_reg == btd_pkg::ST_CLAMP) begin
            sw_reg <= sw_eff;
            sh_reg <= sh_eff;
            dw_reg <= dw_eff;
            dh_reg <= dh_eff;
        end
        if (st_reg == btd_pkg::ST_MUL) begin
            rx_reg       <= div_x_q;
            ry_reg       <= div_y_q;
            remx_reg     <= div_x_r;
            remy_reg     <= div_y_r;
            bsz_reg      <= div_x_q * div_y_q;
            int_mode_reg <= (div_x_r == '0) && (div_y_r == '0);
        end
    end

    assign col_last = sc_reg == sw_reg - 1'b1;
    assign row_last = sr_reg == sh_reg - 1'b1;
    assign nn_hit   = !int_mode_reg && (sr_reg == pr_reg) && (sc_reg == pc_reg);
    assign pcf_sum  = {1'b0, pcf_reg} + {1'b0, remx_reg};
    assign prf_sum  = {1'b0, prf_reg} + {1'b0, remy_reg};

    // position counters; a register write or the end of a frame restarts them
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr_en) begin
            sc_reg <= '0; sr_reg <= '0; bx_reg <= '0; by_reg <= '0;
            ox_reg <= '0; oy_reg <= '0; oc_reg <= '0; orow_reg <= '0;
            pc_reg <= '0; pcf_reg <= '0; pr_reg <= '0; prf_reg <= '0;
        end else if (xfer_in) begin
            // nearest-neighbour pick advance; the frame end below clears it instead
            if (nn_hit && !(col_last && row_last)) begin
                if (oc_reg == dw_reg - 1'b1) begin
                    oc_reg  <= '0;
                    pc_reg  <= '0;
                    pcf_reg <= '0;
                    if (orow_reg == dh_reg - 1'b1) begin
                        orow_reg <= '0;
                        pr_reg   <= '0;
                        prf_reg  <= '0;
                    end else begin
                        orow_reg <= orow_reg + 1'b1;
                        if (prf_sum >= {2'b0, dh_reg}) begin
                            prf_reg <= DW'(prf_sum - {2'b0, dh_reg});
                            pr_reg  <= pr_reg + ry_reg + 1'b1;
                        end else begin
                            prf_reg <= prf_sum[DW-1:0];
                            pr_reg  <= pr_reg + ry_reg;
                        end
                    end
                end else begin
                    oc_reg <= oc_reg + 1'b1;
                    if (pcf_sum >= {2'b0, dw_reg}) begin
                        pcf_reg <= DW'(pcf_sum - {2'b0, dw_reg});
                        pc_reg  <= pc_reg + rx_reg + 1'b1;
                    end else begin
                        pcf_reg <= pcf_sum[DW-1:0];
                        pc_reg  <= pc_reg + rx_reg;
                    end
                end
            end
            // source raster and box position
            if (col_last) begin
                sc_reg <= '0;
                bx_reg <= '0;
                ox_reg <= '0;
                if (row_last) begin
                    sr_reg <= '0; by_reg <= '0; oy_reg <= '0;
                    oc_reg <= '0; orow_reg <= '0;
                    pc_reg <= '0; pcf_reg <= '0; pr_reg <= '0; prf_reg <= '0;
                end else begin
                    sr_reg <= sr_reg + 1'b1;
                    if (by_reg == ry_reg - 1'b1) begin
                        by_reg <= '0;
                        oy_reg <= oy_reg + 1'b1;
                    end else begin
                        by_reg <= by_reg + 1'b1;
                    end
                end
            end else begin
                sc_reg <= sc_reg + 1'b1;
                if (bx_reg == rx_reg - 1'b1) begin
                    bx_reg <= '0;
                    ox_reg <= ox_reg + 1'b1;
                end else begin
                    bx_reg <= bx_reg + 1'b1;
                end
            end
        end
    end

    // latch the item and read its accumulator entry
    always_ff @(posedge aclk) begin
        if (xfer_in) begin
            pix_r_reg   <= s_red_in;
            pix_g_reg   <= s_green_in;
            pix_b_reg   <= s_blue_in;
            idx_reg     <= (ox_reg > IDX_MAX) ? AW'(IDX_MAX) : ox_reg[AW-1:0];
            first_reg   <= (bx_reg == '0) && (by_reg == '0);
            last_reg    <= (bx_reg == rx_reg - 1'b1) && (by_reg == ry_reg - 1'b1);
            lof_reg     <= (ox_reg == dw_reg - 1'b1) && (oy_reg == dh_reg - 1'b1);
            rd_data_reg <= sum_mem[(ox_reg > IDX_MAX) ? AW'(IDX_MAX) : ox_reg[AW-1:0]];
        end
    end

    // read-modify-write; the first pixel of a box overwrites the entry
    always_comb begin
        if (first_reg) begin
            acc_sum = {SUMW'(pix_r_reg), SUMW'(pix_g_reg), SUMW'(pix_b_reg)};
        end else begin
            acc_sum[3*SUMW-1:2*SUMW] = rd_data_reg[3*SUMW-1:2*SUMW] + SUMW'(pix_r_reg);
            acc_sum[2*SUMW-1:SUMW]   = rd_data_reg[2*SUMW-1:SUMW] + SUMW'(pix_g_reg);
            acc_sum[SUMW-1:0]        = rd_data_reg[SUMW-1:0] + SUMW'(pix_b_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            sum_mem[idx_reg] <= acc_sum;
        end
    end

    // averager: 8 quotient bits, divisor walked down from bsz << 7
    assign br = ar_reg >= dsh_reg;
    assign bg = ag_reg >= dsh_reg;
    assign bb = ab_reg >= dsh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_cnt_reg <= '0;
        end else if (st_reg == btd_pkg::ST_ACC) begin
            avg_cnt_reg <= 4'(PW);
        end else if (st_reg == btd_pkg::ST_AVG) begin
            avg_cnt_reg <= avg_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (st_reg == btd_pkg::ST_ACC) begin
            ar_reg  <= DSHW'(acc_sum[3*SUMW-1:2*SUMW]);
            ag_reg  <= DSHW'(acc_sum[2*SUMW-1:SUMW]);
            ab_reg  <= DSHW'(acc_sum[SUMW-1:0]);
            dsh_reg <= {bsz_reg, {(PW-1){1'b0}}};
            qr_reg  <= '0;
            qg_reg  <= '0;
            qb_reg  <= '0;
        end else if (st_reg == btd_pkg::ST_AVG) begin
            ar_reg  <= br ? ar_reg - dsh_reg : ar_reg;
            ag_reg  <= bg ? ag_reg - dsh_reg : ag_reg;
            ab_reg  <= bb ? ab_reg - dsh_reg : ab_reg;
            dsh_reg <= dsh_reg >> 1;
            qr_reg  <= {qr_reg[PW-2:0], br};
            qg_reg  <= {qg_reg[PW-2:0], bg};
            qb_reg  <= {qb_reg[PW-2:0], bb};
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((xfer_in && nn_hit) ||
                     (st_reg == btd_pkg::ST_AVG && avg_cnt_reg == 4'd1)) begin
            m_valid_reg <= 1'b1;
        end else if (xfer_out) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (xfer_in && nn_hit) begin
            m_r_reg   <= s_red_in;
            m_g_reg   <= s_green_in;
            m_b_reg   <= s_blue_in;
            m_lof_reg <= (oc_reg == dw_reg - 1'b1) && (orow_reg == dh_reg - 1'b1);
        end else if (st_reg == btd_pkg::ST_AVG && avg_cnt_reg == 4'd1) begin
            m_r_reg   <= {qr_reg[PW-2:0], br};
            m_g_reg   <= {qg_reg[PW-2:0], bg};
            m_b_reg   <= {qb_reg[PW-2:0], bb};
            m_lof_reg <= lof_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_red_out       = m_r_reg;
    assign m_green_out     = m_g_reg;
    assign m_blue_out      = m_b_reg;
    assign m_last_of_frame = m_lof_reg;

    `BTD_ASSERT_NEXT(a_cfg_restart, cfg_wr_en,
        st_reg == btd_pkg::ST_CLAMP && sc_reg == '0 && sr_reg == '0,
        "register write did not restart the frame")
    `BTD_ASSERT_NEXT(a_box_goes_acc, xfer_in && int_mode_reg && !cfg_wr_en,
        st_reg == btd_pkg::ST_ACC, "box pixel did not enter accumulate")
    `BTD_ASSERT_NEXT(a_avg_emits, st_reg == btd_pkg::ST_AVG && avg_cnt_reg == 4'd1,
        m_valid_reg, "average finished without a result")
    `BTD_ASSERT_NOW(a_col_in_range, st_reg == btd_pkg::ST_IDLE,
        sc_reg < sw_reg && sr_reg < sh_reg, "source position out of frame")
    `BTD_ASSERT_NOW(a_nn_no_result_in_box, xfer_in && int_mode_reg,
        !nn_hit, "nearest-neighbour hit in box mode")

endmodule
